// ===== hdl/argb_blit_pkg.sv =====
// Shared types and constants for the ARGB4444 clipped alpha blit.
// Holds the request and result payload structs and register codes.
// No dependencies.
package argb_blit_pkg;

    localparam int REG_W     = 13;
    localparam int CNT_W     = 12;
    localparam int ADDR_W    = 19;
    localparam int CFG_IDX_W = 2;

    localparam int DEF_SCREEN_WIDTH  = 640;
    localparam int DEF_SCREEN_HEIGHT = 480;

    // Largest image dimension; bigger register values are clamped to it
    localparam logic [REG_W-1:0] DIM_MAX = 13'd4096;

    // Register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_DEST_X     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DEST_Y     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SRC_WIDTH  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SRC_HEIGHT = 2'd3;

    // floor(x / 15) == (x * 2185) >> 15 for all x below 4681
    localparam logic [11:0] DIV15_RECIP = 12'd2185;
    localparam int          DIV15_SHIFT = 15;

    localparam logic [7:0] ALPHA_BYTE = 8'hFF;
    localparam logic [3:0] ALPHA_FULL = 4'hF;

    typedef struct packed {
        logic [15:0] src_pixel;
        logic [31:0] dest_pixel;
    } blit_req_t;

    typedef struct packed {
        logic              write_enable;
        logic [ADDR_W-1:0] dest_address;
        logic [31:0]       pixel_value;
        logic              last_pixel;
    } blit_res_t;

endpackage

// ===== hdl/argb4444_clipped_alpha_blit.sv =====
// Top level of the ARGB4444 clipped alpha blit: position counters, clipping,
// per-channel blend and framebuffer address, as a three-stage pipeline.
// Depends on argb_blit_pkg.
//
//   channel   direction  handshake            payload
//   request   in         in_valid/in_ready    in_data  (argb_blit_pkg::blit_req_t)
//   result    out        out_valid/out_ready  out_data (argb_blit_pkg::blit_res_t)
//   config    in         cfg_we               cfg_index, cfg_data
//
// One request per clock sustained unless a stall on out_ready fills the pipe;
// each request is registered in turn by the clip stage, the blend product and
// address multiply stage and the divide-by-15 reciprocal stage, which drives out_data.
// Reset clears the registers, counters and stage valids; payloads are not reset.
// A stall on out_ready holds only the stages that are full, so in_ready stays
// high while an empty stage remains anywhere in the pipe.
module argb4444_clipped_alpha_blit #(
    parameter int SCREEN_WIDTH  = argb_blit_pkg::DEF_SCREEN_WIDTH,
    parameter int SCREEN_HEIGHT = argb_blit_pkg::DEF_SCREEN_HEIGHT
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    in_valid,
    output logic                                    in_ready,
    input  argb_blit_pkg::blit_req_t                in_data,
    output logic                                    out_valid,
    input  logic                                    out_ready,
    output argb_blit_pkg::blit_res_t                out_data,
    input  logic                                    cfg_we,
    input  logic [argb_blit_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [argb_blit_pkg::REG_W-1:0]         cfg_data
);
    import argb_blit_pkg::*;

    localparam logic signed [13:0] SW14 = 14'(SCREEN_WIDTH);
    localparam logic signed [13:0] SH14 = 14'(SCREEN_HEIGHT);
    localparam logic [12:0]        SW13 = 13'(SCREEN_WIDTH);

    // configuration registers
    logic [REG_W-1:0] dest_x_reg, dest_y_reg, src_width_reg, src_height_reg;

    // position counters
    logic [CNT_W-1:0] col_reg, col_next, row_reg, row_next;

    // stage 1: clipped request
    logic             s1_valid_reg;
    logic             s1_on_reg, s1_last_reg;
    logic [CNT_W-1:0] s1_sx_reg, s1_sy_reg;
    blit_req_t        s1_req_reg;

    // stage 2: blend sums and address
    logic              s2_valid_reg;
    logic              s2_we_reg, s2_last_reg;
    logic [ADDR_W-1:0] s2_addr_reg;
    logic [11:0]       s2_sum_reg [3];

    // stage 3: result
    logic      out_valid_reg;
    blit_res_t out_reg;

    logic s1_adv, s2_adv, out_adv, in_acc;

    assign out_adv  = !out_valid_reg || out_ready;
    assign s2_adv   = !s2_valid_reg || out_adv;
    assign s1_adv   = !s1_valid_reg || s2_adv;
    assign in_ready = s1_adv;
    assign in_acc   = in_valid && in_ready;

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dest_x_reg     <= '0;
            dest_y_reg     <= '0;
            src_width_reg  <= '0;
            src_height_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_DEST_X:     dest_x_reg     <= cfg_data;
                REG_DEST_Y:     dest_y_reg     <= cfg_data;
                REG_SRC_WIDTH:  src_width_reg  <= cfg_data;
                REG_SRC_HEIGHT: src_height_reg <= cfg_data;
                default:        ;
            endcase
        end
    end

    // ---- stage 1 inputs: clip against the screen, step counters ----
    logic [REG_W-1:0]  width_c, height_c, col_inc, row_inc;
    logic              empty, col_end, row_end;
    logic signed [13:0] sx, sy;
    logic              on_screen;

    always_comb
    begin
        width_c  = (src_width_reg  > DIM_MAX) ? DIM_MAX : src_width_reg;
        height_c = (src_height_reg > DIM_MAX) ? DIM_MAX : src_height_reg;
        empty    = (width_c == '0) || (height_c == '0);
        col_inc  = {1'b0, col_reg} + 13'd1;
        row_inc  = {1'b0, row_reg} + 13'd1;
        col_end  = col_inc >= width_c;
        row_end  = row_inc >= height_c;

        sx = {dest_x_reg[REG_W-1], dest_x_reg} + $signed({2'b00, col_reg});
        sy = {dest_y_reg[REG_W-1], dest_y_reg} + $signed({2'b00, row_reg});
        on_screen = !sx[13] && (sx < SW14) && !sy[13] && (sy < SH14) && !empty;

        col_next = col_reg;
        row_next = row_reg;
        if (empty)
        begin
            col_next = '0;
            row_next = '0;
        end
        else if (col_end)
        begin
            col_next = '0;
            row_next = row_end ? '0 : row_inc[CNT_W-1:0];
        end
        else
        begin
            col_next = col_inc[CNT_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg      <= '0;
            row_reg      <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_acc)
            begin
                col_reg <= col_next;
                row_reg <= row_next;
            end
            if (s1_adv)
                s1_valid_reg <= in_acc;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            s1_req_reg  <= in_data;
            s1_on_reg   <= on_screen;
            s1_last_reg <= empty || (col_end && row_end);
            s1_sx_reg   <= sx[CNT_W-1:0];
            s1_sy_reg   <= sy[CNT_W-1:0];
        end
    end

    // ---- stage 2: blend products, framebuffer address ----
    logic [3:0]  alpha, alpha_inv;
    logic        s2_we;
    logic [24:0] addr_full;
    logic [11:0] sum [3];
    logic [7:0]  src_c [3];
    logic [7:0]  dst_c [3];

    always_comb
    begin
        alpha     = s1_req_reg.src_pixel[15:12];
        alpha_inv = ALPHA_FULL - alpha;
        s2_we     = s1_on_reg && (alpha != '0);
        addr_full = 25'(s1_sy_reg * SW13) + {13'd0, s1_sx_reg};
        for (int i = 0; i < 3; i++)
        begin
            // channel nibble times 17 is the nibble repeated
            src_c[i] = {2{s1_req_reg.src_pixel[i*4 +: 4]}};
            dst_c[i] = s1_req_reg.dest_pixel[i*8 +: 8];
            // alpha 15 gives c*15/15, the opaque colour, with no special case
            sum[i]   = 12'(src_c[i] * alpha) + 12'(dst_c[i] * alpha_inv);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_valid_reg <= 1'b0;
        else if (s2_adv)
            s2_valid_reg <= s1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (s2_adv && s1_valid_reg)
        begin
            s2_we_reg   <= s2_we;
            s2_last_reg <= s1_last_reg;
            s2_addr_reg <= s2_we ? addr_full[ADDR_W-1:0] : '0;
            for (int i = 0; i < 3; i++)
                s2_sum_reg[i] <= sum[i];
        end
    end

    // ---- stage 3: divide by 15, assemble the word ----
    logic [23:0] quot_full [3];
    logic [7:0]  chan [3];
    blit_res_t   res;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            quot_full[i] = s2_sum_reg[i] * DIV15_RECIP;
            chan[i]      = quot_full[i][DIV15_SHIFT +: 8];
        end
        res.write_enable = s2_we_reg;
        res.dest_address = s2_addr_reg;
        res.pixel_value  = s2_we_reg ? {ALPHA_BYTE, chan[2], chan[1], chan[0]} : '0;
        res.last_pixel   = s2_last_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_adv)
            out_valid_reg <= s2_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (out_adv && s2_valid_reg)
            out_reg <= res;
    end

    // ---- checks ----
    a_idle_word_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.write_enable |->
            out_data.dest_address == '0 && out_data.pixel_value == '0)
        else $error("unwritten result carries a non-zero address or value");

    a_opaque_top: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.write_enable |-> out_data.pixel_value[31:24] == ALPHA_BYTE)
        else $error("written pixel lacks the 0xFF top byte");

    a_empty_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc && empty |=> col_reg == '0 && row_reg == '0)
        else $error("counters moved on an empty image");

    a_last_wraps: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc && col_end && row_end |=> col_reg == '0 && row_reg == '0)
        else $error("counters did not wrap after the final pixel");

endmodule
